/* src/mbp_pkg.sv */
// Package for the MIDI byte parser: command codes, queue entry type,
// result kinds and tick constants. No dependencies.
`default_nettype none
package mbp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] CMD_FLUSH   = 4'd0;
  localparam logic [3:0] CMD_DATA    = 4'd1;
  localparam logic [3:0] CMD_CLOCK   = 4'd2;
  localparam logic [3:0] CMD_IGNORE  = 4'd3;
  localparam logic [3:0] CMD_START   = 4'd4;
  localparam logic [3:0] CMD_STOP    = 4'd5;
  localparam logic [3:0] CMD_SYX_ON  = 4'd6;
  localparam logic [3:0] CMD_SYX_OFF = 4'd7;
  localparam logic [3:0] CMD_STATUS  = 4'd8;

  localparam logic [6:0] LOW_CLOCK   = 7'h78;
  localparam logic [6:0] LOW_SENSE   = 7'h7e;
  localparam logic [6:0] LOW_START   = 7'h7a;
  localparam logic [6:0] LOW_STOP    = 7'h7c;
  localparam logic [6:0] LOW_SYX_ON  = 7'h70;
  localparam logic [6:0] LOW_SYX_OFF = 7'h77;

  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_CLOCK = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;

  // remainder + 26666 = 2 units + (remainder + 6666); a third unit if that reaches 10000
  localparam logic [14:0] TICK_STEP_LOW = 15'd6666;
  localparam logic [14:0] TICK_UNIT     = 15'd10000;

  typedef struct packed {
    logic [3:0] code;
    logic [6:0] low;
  } cmd_t;

endpackage
`default_nettype wire

/* src/mbp_front.sv */
// Front end: accepts input items and classifies each into a queue command.
// Depends on mbp_pkg.
`default_nettype none
module mbp_front
  import mbp_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       operation,
  input  wire logic [7:0] rx_byte,
  output logic            push,
  output cmd_t            push_cmd,
  input  wire logic       full
);

  always_comb begin
    push_cmd.low = rx_byte[6:0];
    if (operation) begin
      push_cmd.code = CMD_FLUSH;
    end else if (!rx_byte[7]) begin
      push_cmd.code = CMD_DATA;
    end else begin
      case (rx_byte[6:0])
        LOW_CLOCK:   push_cmd.code = CMD_CLOCK;
        LOW_SENSE:   push_cmd.code = CMD_IGNORE;
        LOW_START:   push_cmd.code = CMD_START;
        LOW_STOP:    push_cmd.code = CMD_STOP;
        LOW_SYX_ON:  push_cmd.code = CMD_SYX_ON;
        LOW_SYX_OFF: push_cmd.code = CMD_SYX_OFF;
        default:     push_cmd.code = CMD_STATUS;
      endcase
    end
  end

  assign in_ready = !full;
  assign push     = in_valid && !full;

endmodule
`default_nettype wire

/* src/mbp_queue.sv */
// Short command queue between front and back ends.
// Depends on mbp_pkg for the entry type.
`default_nettype none
module mbp_queue
  import mbp_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd,
  input  wire logic pop
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/mbp_back.sv */
// Back end: executes queued commands against parser state and holds one result.
// Depends on mbp_pkg.
`default_nettype none
module mbp_back
  import mbp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  cmd_t            head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [6:0]      status_low,
  output logic [6:0]      first_data,
  output logic [6:0]      second_data,
  output logic [1:0]      tick_count
);

  logic [6:0]  latched_status;
  logic [6:0]  held_first_data;
  logic [1:0]  data_phase;
  logic        sysex_active;
  logic [13:0] tick_remainder;

  logic [6:0]  latched_status_next;
  logic [6:0]  held_first_data_next;
  logic [1:0]  data_phase_next;
  logic        sysex_active_next;
  logic [13:0] tick_remainder_next;

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [6:0]  res_status;
  logic [6:0]  res_first;
  logic [6:0]  res_second;
  logic [1:0]  res_ticks;
  logic [14:0] tick_sum;
  logic        pending;

  assign pop      = head_valid && (!out_valid || out_ready);
  assign pending  = (data_phase != PHASE_IDLE);
  assign tick_sum = {1'b0, tick_remainder} + TICK_STEP_LOW;

  always_comb begin
    latched_status_next  = latched_status;
    held_first_data_next = held_first_data;
    data_phase_next      = data_phase;
    sysex_active_next    = sysex_active;
    tick_remainder_next  = tick_remainder;
    res_valid            = 1'b0;
    res_kind             = KIND_MSG;
    res_status           = '0;
    res_first            = '0;
    res_second           = '0;
    res_ticks            = '0;
    case (head_cmd.code)
      CMD_FLUSH: begin
        if (pending) begin
          res_valid       = 1'b1;
          res_status      = latched_status;
          res_first       = held_first_data;
          data_phase_next = PHASE_IDLE;
        end
      end
      CMD_CLOCK: begin
        res_valid = 1'b1;
        res_kind  = KIND_CLOCK;
        if (tick_sum >= TICK_UNIT) begin
          res_ticks           = 2'd3;
          tick_remainder_next = 14'(tick_sum - TICK_UNIT);
        end else begin
          res_ticks           = 2'd2;
          tick_remainder_next = tick_sum[13:0];
        end
      end
      CMD_IGNORE: begin
      end
      CMD_START: begin
        res_valid = 1'b1;
        res_kind  = KIND_START;
      end
      CMD_STOP: begin
        res_valid = 1'b1;
        res_kind  = KIND_STOP;
      end
      CMD_SYX_ON:  sysex_active_next = 1'b1;
      CMD_SYX_OFF: sysex_active_next = 1'b0;
      CMD_STATUS: begin
        if (pending) begin
          res_valid  = 1'b1;
          res_status = latched_status;
          res_first  = held_first_data;
        end
        latched_status_next  = head_cmd.low;
        held_first_data_next = '0;
        data_phase_next      = PHASE_FIRST;
      end
      CMD_DATA: begin
        if (!sysex_active) begin
          if (data_phase == PHASE_FIRST) begin
            held_first_data_next = head_cmd.low;
            data_phase_next      = PHASE_SECOND;
          end else if (data_phase == PHASE_SECOND) begin
            res_valid       = 1'b1;
            res_status      = latched_status;
            res_first       = held_first_data;
            res_second      = head_cmd.low;
            data_phase_next = PHASE_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      latched_status <= latched_status_next;
    end
    if (pop && res_valid) begin
      kind        <= res_kind;
      status_low  <= res_status;
      first_data  <= res_first;
      second_data <= res_second;
      tick_count  <= res_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_first_data <= '0;
      data_phase      <= PHASE_IDLE;
      sysex_active    <= 1'b0;
      tick_remainder  <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        held_first_data <= held_first_data_next;
        data_phase      <= data_phase_next;
        sysex_active    <= sysex_active_next;
        tick_remainder  <= tick_remainder_next;
      end
      if (!out_valid || out_ready) begin
        out_valid <= pop && res_valid;
      end
    end
  end

endmodule
`default_nettype wire

/* src/midi_byte_parser_with_clock_ticks_core.sv */
// MIDI byte parser with clock ticks, one input item per cycle sustained while the
// command queue is not full. An accepted item is written into the command queue
// and at the earliest moves on from there into the output result register; the
// output register and the queue of QueueDepth entries let input and output
// stall independently. Clock bytes give 2 or 3 ticks, channel messages carry
// their status with bit 7 removed.
// Depends on mbp_pkg, mbp_front, mbp_queue, mbp_back.
`default_nettype none
module midi_byte_parser_with_clock_ticks_core
  import mbp_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       operation,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [6:0]      status_low,
  output logic [6:0]      first_data,
  output logic [6:0]      second_data,
  output logic [1:0]      tick_count
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  mbp_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .operation(operation),
    .rx_byte  (rx_byte),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  mbp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop)
  );

  mbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .status_low (status_low),
    .first_data (first_data),
    .second_data(second_data),
    .tick_count (tick_count)
  );

endmodule
`default_nettype wire

/* src/mbp_checker.sv */
// Port-level checks for the MIDI byte parser, bound to the top level.
// Depends on mbp_pkg for result kinds.
`default_nettype none
module mbp_checker
  import mbp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] kind,
  input wire logic [6:0] status_low,
  input wire logic [6:0] first_data,
  input wire logic [6:0] second_data,
  input wire logic [1:0] tick_count
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(tick_count))
    else $error("stalled result changed");

  a_clock_ticks: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CLOCK |-> (tick_count == 2'd2 || tick_count == 2'd3))
    else $error("clock result with bad tick count");

  a_no_ticks: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_CLOCK |-> tick_count == 2'd0)
    else $error("ticks on non-clock result");

  a_run_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_START || kind == KIND_STOP || kind == KIND_CLOCK)
      |-> status_low == 7'd0 && first_data == 7'd0 && second_data == 7'd0)
    else $error("message fields set on non-message result");

endmodule

bind midi_byte_parser_with_clock_ticks_core mbp_checker u_mbp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .status_low (status_low),
  .first_data (first_data),
  .second_data(second_data),
  .tick_count (tick_count)
);
`default_nettype wire
